>>> rtl/ssi_pkg.sv
package ssi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CW      = 32;
    localparam int RADW    = 31;
    localparam int VW      = 33;
    localparam int PW      = 66;
    localparam int AW      = 66;
    localparam int BW      = 67;
    localparam int MW      = 66;
    localparam int HW      = 33;
    localparam int SQW     = 132;
    localparam int DW      = 134;
    localparam int DIVW    = 99;
    localparam int TW      = 32;
    localparam int Q_DEPTH = 4;

    localparam int SQ_STEPS  = SQW / 2;
    localparam int DIV_STEPS = TW;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic [TW-1:0]        hit_time;
        logic signed [CW-1:0] offset_x;
        logic signed [CW-1:0] offset_y;
        logic signed [CW-1:0] offset_z;
        logic                 overlaps;
    } t_out;

    typedef struct packed {
        logic signed [VW-1:0] rel_x;
        logic signed [VW-1:0] rel_y;
        logic signed [VW-1:0] rel_z;
        logic signed [VW-1:0] dir_x;
        logic signed [VW-1:0] dir_y;
        logic signed [VW-1:0] dir_z;
    } t_geo;

    typedef struct packed {
        logic           hit;
        logic           over;
        logic [SQW-1:0] d;
        logic [MW-1:0]  nb;
        logic [AW-1:0]  a;
        t_geo           geo;
    } t_fq;

    typedef struct packed {
        logic                 hit;
        logic                 over;
        logic [SQW-1:0]       n;
        logic [SQW-1:0]       res;
        logic [MW-1:0]        nb;
        logic [AW-1:0]        a;
        logic [DIVW-1:0]      rem;
        logic [TW-1:0]        q;
        logic                 sat;
        t_geo                 geo;
        logic signed [PW-1:0] p_x;
        logic signed [PW-1:0] p_y;
        logic signed [PW-1:0] p_z;
    } t_bs;

endpackage

>>> rtl/segment_sphere_intersect_unit.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_item (t_in)
// result    out        o_valid / i_stall    o_item (t_out)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while i_stall stays low; an item passes the front
// pipeline, the queue, then the back pipeline (load, 66 square root steps,
// numerator, saturation check, divide steps, products, output)
// synchronous active low reset clears valids, queue pointers and center registers
// the front and back pipelines freeze separately; the 4 entry queue between them
// absorbs a stalled back end; o_stall = queue full and last front stage valid
module segment_sphere_intersect_unit import ssi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  t_in           i_item,
    output logic          o_valid,
    input  logic          i_stall,
    output t_out          o_item,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [CW-1:0] i_cfg_data
);

    logic signed [CW-1:0] r_cx, r_cy, r_cz;
    logic [RADW-1:0]      r_rad;

    t_fq  fq_w, fq_r;
    logic fq_wvalid, fq_full, fq_rvalid, fq_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADW'(1) << FRAC_BITS_DEF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_cx  <= i_cfg_data;
                CFG_CENTER_Y: r_cy  <= i_cfg_data;
                CFG_CENTER_Z: r_cz  <= i_cfg_data;
                CFG_RADIUS:   r_rad <= i_cfg_data[RADW-1:0];
                default:      ;
            endcase
        end
    end

    ssi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .i_cx       (r_cx),
        .i_cy       (r_cy),
        .i_cz       (r_cz),
        .i_rad      (r_rad),
        .o_fq       (fq_w),
        .o_fq_valid (fq_wvalid),
        .i_fq_full  (fq_full)
    );

    ssi_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (fq_wvalid),
        .i_wdata  (fq_w),
        .o_full   (fq_full),
        .o_rvalid (fq_rvalid),
        .o_rdata  (fq_r),
        .i_pop    (fq_pop)
    );

    ssi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_rvalid),
        .i_fq    (fq_r),
        .o_pop   (fq_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

>>> rtl/ssi_front.sv
module ssi_front import ssi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  t_in                    i_item,
    input  logic signed [CW-1:0]   i_cx,
    input  logic signed [CW-1:0]   i_cy,
    input  logic signed [CW-1:0]   i_cz,
    input  logic [RADW-1:0]        i_rad,
    output t_fq                    o_fq,
    output logic                   o_fq_valid,
    input  logic                   i_fq_full
);

    localparam int NF = 7;
    localparam int SW = 68;

    typedef struct packed {
        logic endin;
        logic anz;
        logic bneg;
        logic ble0;
        logic cneg;
        logic nbgea;
    } t_flg;

    logic [NF-1:0] r_fv;
    logic          adv;

    t_geo                 r1_geo;
    logic signed [VW-1:0] r1_rend [3];

    t_geo                 r2_geo;
    logic signed [PW-1:0] r2_pd [3];
    logic signed [PW-1:0] r2_pb [3];
    logic signed [PW-1:0] r2_ps [3];
    logic signed [PW-1:0] r2_pe [3];
    logic [2*RADW-1:0]    r2_rad2;

    t_geo                 r3_geo;
    logic [AW-1:0]        r3_a;
    logic signed [BW-1:0] r3_b;
    logic signed [BW-1:0] r3_c;
    logic                 r3_endin;

    t_geo          r4_geo;
    logic [AW-1:0] r4_a;
    logic [MW-1:0] r4_magb;
    logic [MW-1:0] r4_magc;
    t_flg          r4_f;

    t_geo          r5_geo;
    logic [AW-1:0] r5_a;
    logic [MW-1:0] r5_nb;
    t_flg          r5_f;
    logic [PW-1:0] r5_bhh, r5_bhl, r5_bll;
    logic [PW-1:0] r5_ahh, r5_ahl, r5_alh, r5_all;

    t_geo           r6_geo;
    logic [AW-1:0]  r6_a;
    logic [MW-1:0]  r6_nb;
    t_flg           r6_f;
    logic [SQW-1:0] r6_bsq;
    logic [SQW-1:0] r6_ac;

    t_fq r_fq;

    logic signed [VW-1:0] st [3];
    logic signed [VW-1:0] en [3];
    logic signed [VW-1:0] ce [3];
    logic signed [SW-1:0] sa, sb, ss, se, rr, sc, sd;
    logic signed [BW-1:0] nb_s;
    logic signed [DW-1:0] dv;
    logic                 dpos;

    assign adv        = !r_fv[NF-1] || !i_fq_full;
    assign o_stall    = !adv;
    assign o_fq_valid = r_fv[NF-1];
    assign o_fq       = r_fq;

    always_comb begin
        st[0] = VW'(i_item.start_x);
        st[1] = VW'(i_item.start_y);
        st[2] = VW'(i_item.start_z);
        en[0] = VW'(i_item.end_x);
        en[1] = VW'(i_item.end_y);
        en[2] = VW'(i_item.end_z);
        ce[0] = VW'(i_cx);
        ce[1] = VW'(i_cy);
        ce[2] = VW'(i_cz);
    end

    always_comb begin
        sa = SW'(r2_pd[0]) + SW'(r2_pd[1]) + SW'(r2_pd[2]);
        sb = SW'(r2_pb[0]) + SW'(r2_pb[1]) + SW'(r2_pb[2]);
        ss = SW'(r2_ps[0]) + SW'(r2_ps[1]) + SW'(r2_ps[2]);
        se = SW'(r2_pe[0]) + SW'(r2_pe[1]) + SW'(r2_pe[2]);
        rr = $signed({6'b0, r2_rad2});
        sc = ss - rr;
        sd = se - rr;
        nb_s = -r3_b;
        if (r6_f.cneg) begin
            dv = $signed({2'b0, r6_bsq}) + $signed({2'b0, r6_ac});
        end else begin
            dv = $signed({2'b0, r6_bsq}) - $signed({2'b0, r6_ac});
        end
        dpos = !dv[DW-1] && (dv != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (adv) begin
            r_fv <= {r_fv[NF-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1: differences
            r1_geo.rel_x <= st[0] - ce[0];
            r1_geo.rel_y <= st[1] - ce[1];
            r1_geo.rel_z <= st[2] - ce[2];
            r1_geo.dir_x <= en[0] - st[0];
            r1_geo.dir_y <= en[1] - st[1];
            r1_geo.dir_z <= en[2] - st[2];
            for (int i = 0; i < 3; i++) begin
                r1_rend[i] <= en[i] - ce[i];
            end

            // stage 2: products
            r2_geo     <= r1_geo;
            r2_pd[0]   <= r1_geo.dir_x * r1_geo.dir_x;
            r2_pd[1]   <= r1_geo.dir_y * r1_geo.dir_y;
            r2_pd[2]   <= r1_geo.dir_z * r1_geo.dir_z;
            r2_pb[0]   <= r1_geo.rel_x * r1_geo.dir_x;
            r2_pb[1]   <= r1_geo.rel_y * r1_geo.dir_y;
            r2_pb[2]   <= r1_geo.rel_z * r1_geo.dir_z;
            r2_ps[0]   <= r1_geo.rel_x * r1_geo.rel_x;
            r2_ps[1]   <= r1_geo.rel_y * r1_geo.rel_y;
            r2_ps[2]   <= r1_geo.rel_z * r1_geo.rel_z;
            for (int i = 0; i < 3; i++) begin
                r2_pe[i] <= r1_rend[i] * r1_rend[i];
            end
            r2_rad2    <= {{RADW{1'b0}}, i_rad} * {{RADW{1'b0}}, i_rad};

            // stage 3: dot products
            r3_geo   <= r2_geo;
            r3_a     <= sa[AW-1:0];
            r3_b     <= sb[BW-1:0];
            r3_c     <= sc[BW-1:0];
            r3_endin <= sd[SW-1];

            // stage 4: magnitudes and flags
            r4_geo     <= r3_geo;
            r4_a       <= r3_a;
            r4_magb    <= r3_b[BW-1] ? nb_s[MW-1:0] : r3_b[MW-1:0];
            r4_magc    <= r3_c[BW-1] ? MW'(-r3_c) : r3_c[MW-1:0];
            r4_f.endin <= r3_endin;
            r4_f.anz   <= (r3_a != '0);
            r4_f.bneg  <= r3_b[BW-1];
            r4_f.ble0  <= r3_b[BW-1] || (r3_b == '0);
            r4_f.cneg  <= r3_c[BW-1];
            r4_f.nbgea <= (nb_s[MW-1:0] >= r3_a);

            // stage 5: partial products
            r5_geo <= r4_geo;
            r5_a   <= r4_a;
            r5_nb  <= r4_magb;
            r5_f   <= r4_f;
            r5_bhh <= r4_magb[MW-1:HW] * r4_magb[MW-1:HW];
            r5_bhl <= r4_magb[MW-1:HW] * r4_magb[HW-1:0];
            r5_bll <= r4_magb[HW-1:0] * r4_magb[HW-1:0];
            r5_ahh <= r4_a[AW-1:HW] * r4_magc[MW-1:HW];
            r5_ahl <= r4_a[AW-1:HW] * r4_magc[HW-1:0];
            r5_alh <= r4_a[HW-1:0] * r4_magc[MW-1:HW];
            r5_all <= r4_a[HW-1:0] * r4_magc[HW-1:0];

            // stage 6: wide square and product
            r6_geo <= r5_geo;
            r6_a   <= r5_a;
            r6_nb  <= r5_nb;
            r6_f   <= r5_f;
            r6_bsq <= (SQW'(r5_bhh) << (2*HW)) + (SQW'(r5_bhl) << (HW+1)) + SQW'(r5_bll);
            r6_ac  <= (SQW'(r5_ahh) << (2*HW)) + ((SQW'(r5_ahl) + SQW'(r5_alh)) << HW)
                      + SQW'(r5_all);

            // stage 7: discriminant and classification
            r_fq.geo  <= r6_geo;
            r_fq.a    <= r6_a;
            r_fq.nb   <= r6_nb;
            r_fq.d    <= dv[SQW-1:0];
            r_fq.hit  <= r6_f.anz && !dv[DW-1] && !r6_f.cneg && r6_f.ble0;
            r_fq.over <= r6_f.bneg ? (r6_f.nbgea ? r6_f.endin : dpos) : r6_f.cneg;
        end
    end

endmodule

>>> rtl/ssi_queue.sv
module ssi_queue import ssi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wvalid,
    input  t_fq  i_wdata,
    output logic o_full,
    output logic o_rvalid,
    output t_fq  o_rdata,
    input  logic i_pop
);

    localparam int PTRW = $clog2(Q_DEPTH);
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    t_fq             r_mem [Q_DEPTH];
    logic [PTRW-1:0] r_wp;
    logic [PTRW-1:0] r_rp;
    logic [CNTW-1:0] r_count;
    logic            push;

    assign o_full   = (r_count == CNTW'(Q_DEPTH));
    assign o_rvalid = (r_count != '0);
    assign o_rdata  = r_mem[r_rp];
    assign push     = i_wvalid && !o_full;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + CNTW'(push) - CNTW'(i_pop);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

>>> rtl/ssi_back.sv
module ssi_back import ssi_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_fq  i_fq,
    output logic o_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_item
);

    localparam int S_NUM  = SQ_STEPS + 1;
    localparam int S_SAT  = S_NUM + 1;
    localparam int S_DIV0 = S_SAT + 1;
    localparam int S_PRD  = S_DIV0 + DIV_STEPS;
    localparam int NST    = S_PRD + 1;

    t_bs        r_st [NST];
    t_bs        n_st [NST];
    logic [NST:0] r_bv;
    t_out       r_out;
    logic       adv;

    function automatic logic signed [CW-1:0] f_off(logic signed [PW-1:0] p,
                                                   logic signed [VW-1:0] rel);
        logic signed [PW:0] s;
        s = (PW+1)'(p >>> FRAC_BITS) + (PW+1)'(rel);
        if ((s[PW:CW-1] == '0) || (s[PW:CW-1] == '1)) begin
            return s[CW-1:0];
        end
        return s[PW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    assign adv     = !r_bv[NST] || !i_stall;
    assign o_pop   = adv && i_valid;
    assign o_valid = r_bv[NST];
    assign o_item  = r_out;

    always_comb begin
        n_st[0]      = '0;
        n_st[0].hit  = i_fq.hit;
        n_st[0].over = i_fq.over;
        n_st[0].n    = i_fq.d;
        n_st[0].nb   = i_fq.nb;
        n_st[0].a    = i_fq.a;
        n_st[0].geo  = i_fq.geo;
    end

    for (genvar g = 1; g < NST; g++) begin : g_stage
        if (g <= SQ_STEPS) begin : g_sqrt
            always_comb begin
                logic [SQW-1:0] bitv;
                logic [SQW-1:0] tmp;
                bitv    = SQW'(1) << (2 * (SQ_STEPS - g));
                tmp     = r_st[g-1].res + bitv;
                n_st[g] = r_st[g-1];
                n_st[g].res = r_st[g-1].res >> 1;
                if (r_st[g-1].n >= tmp) begin
                    n_st[g].n   = r_st[g-1].n - tmp;
                    n_st[g].res = (r_st[g-1].res >> 1) + bitv;
                end
            end
        end else if (g == S_NUM) begin : g_num
            always_comb begin
                n_st[g]     = r_st[g-1];
                n_st[g].rem = DIVW'(r_st[g-1].nb - r_st[g-1].res[MW-1:0]) << FRAC_BITS;
            end
        end else if (g == S_SAT) begin : g_sat
            always_comb begin
                n_st[g]     = r_st[g-1];
                n_st[g].sat = (r_st[g-1].rem >= (DIVW'(r_st[g-1].a) << TW));
            end
        end else if (g < S_PRD) begin : g_div
            always_comb begin
                logic [DIVW-1:0] sh;
                sh      = DIVW'(r_st[g-1].a) << (TW - 1 - (g - S_DIV0));
                n_st[g] = r_st[g-1];
                if (r_st[g-1].rem >= sh) begin
                    n_st[g].rem = r_st[g-1].rem - sh;
                    n_st[g].q[TW-1-(g-S_DIV0)] = 1'b1;
                end
            end
        end else begin : g_prd
            always_comb begin
                logic [TW-1:0] tq;
                tq          = r_st[g-1].sat ? '1 : r_st[g-1].q;
                n_st[g]     = r_st[g-1];
                n_st[g].q   = tq;
                n_st[g].p_x = r_st[g-1].geo.dir_x * $signed({1'b0, tq});
                n_st[g].p_y = r_st[g-1].geo.dir_y * $signed({1'b0, tq});
                n_st[g].p_z = r_st[g-1].geo.dir_z * $signed({1'b0, tq});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (adv) begin
            r_bv <= {r_bv[NST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st <= n_st;
            r_out.hit      <= r_st[NST-1].hit;
            r_out.overlaps <= r_st[NST-1].over;
            if (r_st[NST-1].hit) begin
                r_out.hit_time <= r_st[NST-1].q;
                r_out.offset_x <= f_off(r_st[NST-1].p_x, r_st[NST-1].geo.rel_x);
                r_out.offset_y <= f_off(r_st[NST-1].p_y, r_st[NST-1].geo.rel_y);
                r_out.offset_z <= f_off(r_st[NST-1].p_z, r_st[NST-1].geo.rel_z);
            end else begin
                r_out.hit_time <= '0;
                r_out.offset_x <= '0;
                r_out.offset_y <= '0;
                r_out.offset_z <= '0;
            end
        end
    end

endmodule

>>> verif/tb_top.sv
module tb_top import ssi_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic bool_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 150;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    t_in           i_item;
    logic          o_valid;
    logic          i_stall;
    t_out          o_item;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [CW-1:0] i_cfg_data;

    segment_sphere_intersect_unit DUT (.*);

    t_in  seg_pending[$];
    t_out hit_expected[$];

    logic signed [CW-1:0] sph_cx, sph_cy, sph_cz;
    logic [RADW-1:0]      sph_rad;

    int  mismatches;
    int  idle_cycles;
    int  cycle_cnt;
    int  gap_left;
    int  hold_left;
    bool_t quiet;
    logic run_done;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [191:0] floor_sqrt(logic [191:0] n);
        logic [191:0] res;
        logic [191:0] b;
        res = '0;
        for (int k = 95; k >= 0; k--) begin
            b = 192'd1 << (2 * k);
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] sat_s32(logic signed [191:0] v);
        if (v > 192'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -192'sd2147483648) return 32'h8000_0000;
        return v[CW-1:0];
    endfunction

    function automatic t_out predict_hit(t_in it);
        logic signed [CW-1:0]  s[3], e[3], c[3];
        logic signed [191:0]   rel[3], dir[3], rel_end[3];
        logic signed [191:0]   sq_len, proj, d_start, d_end, rad2, cterm, disc, p, tqs, tmp;
        logic [191:0]          num, q;
        logic [31:0]           tq;
        t_out                  r;
        s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
        e[0] = it.end_x;   e[1] = it.end_y;   e[2] = it.end_z;
        c[0] = sph_cx;     c[1] = sph_cy;     c[2] = sph_cz;
        sq_len = '0; proj = '0; d_start = '0; d_end = '0;
        for (int i = 0; i < 3; i++) begin
            rel[i] = s[i];
            tmp = c[i];
            rel[i] = rel[i] - tmp;
            dir[i] = e[i];
            tmp = s[i];
            dir[i] = dir[i] - tmp;
            rel_end[i] = rel[i] + dir[i];
            sq_len  = sq_len + dir[i] * dir[i];
            proj    = proj + rel[i] * dir[i];
            d_start = d_start + rel[i] * rel[i];
            d_end   = d_end + rel_end[i] * rel_end[i];
        end
        rad2 = '0;
        rad2[61:0] = 62'(sph_rad) * 62'(sph_rad);
        cterm = d_start - rad2;
        disc  = proj * proj - sq_len * cterm;
        r = '0;
        if (proj < 0) begin
            if (-proj >= sq_len) r.overlaps = (d_end - rad2) < 0;
            else                 r.overlaps = disc > 0;
        end else begin
            r.overlaps = cterm < 0;
        end
        if (sq_len != 0 && disc >= 0 && cterm >= 0 && proj <= 0) begin
            num = -proj - floor_sqrt(disc);
            num = num << FRAC_BITS_DEF;
            q   = num / sq_len;
            tq  = (q[191:32] != 0) ? 32'hFFFF_FFFF : q[31:0];
            r.hit      = 1'b1;
            r.hit_time = tq;
            tqs = '0;
            tqs[31:0] = tq;
            p = (dir[0] * tqs) >>> FRAC_BITS_DEF;
            r.offset_x = sat_s32(p + rel[0]);
            p = (dir[1] * tqs) >>> FRAC_BITS_DEF;
            r.offset_y = sat_s32(p + rel[1]);
            p = (dir[2] * tqs) >>> FRAC_BITS_DEF;
            r.offset_z = sat_s32(p + rel[2]);
        end
        return r;
    endfunction

    function automatic longint rnd_span(longint span);
        longint u;
        u = longint'({$urandom, $urandom} & 64'h3FFF_FFFF_FFFF_FFFF);
        return (u % (2 * span + 1)) - span;
    endfunction

    function automatic t_in make_segment();
        t_in    it;
        longint scale, sx, sy, sz;
        int     mode;
        mode = $urandom_range(0, 99);
        scale = (sph_rad == 0) ? 65536 : longint'(sph_rad);
        if ($urandom_range(0, 3) == 0) scale = longint'(1) << $urandom_range(4, 31);
        sx = rnd_span(2 * scale);
        sy = rnd_span(2 * scale);
        sz = rnd_span(2 * scale);
        if (mode < 20) begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            it.start_x = CW'(longint'(sph_cx) + sx);
            it.start_y = CW'(longint'(sph_cy) + sy);
            it.start_z = CW'(longint'(sph_cz) + sz);
            if (mode < 30) begin
                it.end_x = it.start_x;
                it.end_y = it.start_y;
                it.end_z = it.start_z;
            end else if (mode < 75) begin
                it.end_x = CW'(longint'(sph_cx) - sx + rnd_span(scale / 2));
                it.end_y = CW'(longint'(sph_cy) - sy + rnd_span(scale / 2));
                it.end_z = CW'(longint'(sph_cz) - sz + rnd_span(scale / 2));
            end else begin
                it.end_x = CW'(longint'(sph_cx) + rnd_span(2 * scale));
                it.end_y = CW'(longint'(sph_cy) + rnd_span(2 * scale));
                it.end_z = CW'(longint'(sph_cz) + rnd_span(2 * scale));
            end
        end
        return it;
    endfunction

    function automatic t_in seg(int sx, int sy, int sz, int ex, int ey, int ez);
        t_in it;
        it.start_x = sx; it.start_y = sy; it.start_z = sz;
        it.end_x   = ex; it.end_y   = ey; it.end_z   = ez;
        return it;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) hit_expected.push_back(predict_hit(i_item));
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (seg_pending.size() > 0) begin
                    i_valid <= 1'b1;
                    i_item  <= seg_pending.pop_front();
                    if (quiet) gap_left <= 0;
                    else begin
                        case ($urandom_range(0, 99)) inside
                            [0:59]:  gap_left <= 0;
                            [60:89]: gap_left <= $urandom_range(1, 3);
                            [90:97]: gap_left <= $urandom_range(4, 15);
                            default: gap_left <= $urandom_range(30, 100);
                        endcase
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
            cycle_cnt <= 0;
            quiet     <= 1'b0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if ($urandom_range(0, 299) == 0) quiet <= !quiet;
            if (o_valid && !i_stall) begin
                if (hit_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %p", o_item);
                end else begin
                    want = hit_expected.pop_front();
                    if (o_item !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, o_item);
                    end
                end
            end
            if (cycle_cnt == 1500) begin
                hold_left <= 400;
                i_stall   <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 999)) inside
                    [0:649]:   i_stall <= 1'b0;
                    [650:994]: i_stall <= 1'b1;
                    default: begin
                        hold_left <= $urandom_range(30, 150);
                        i_stall   <= 1'b1;
                    end
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !run_done) begin
            $display("[segment_sphere_intersect_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER_X: sph_cx = data;
            CFG_CENTER_Y: sph_cy = data;
            CFG_CENTER_Z: sph_cz = data;
            CFG_RADIUS:   sph_rad = data[RADW-1:0];
        endcase
    endtask

    task automatic drain_all();
        while (seg_pending.size() > 0 || i_valid || hit_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                              logic [CW-1:0] rad);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) seg_pending.push_back(make_segment());
        drain_all();
    endtask

    initial begin
        localparam int ONE = 65536;
        mismatches = 0;
        run_done   = 1'b0;
        sph_cx = '0; sph_cy = '0; sph_cz = '0; sph_rad = 31'd65536;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_stall    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default sphere: unit radius at the origin
        seg_pending.push_back(seg(-2*ONE, 0, 0, 2*ONE, 0, 0));
        seg_pending.push_back(seg(-3*ONE, ONE/2, 0, -2*ONE, ONE/2, 0));
        seg_pending.push_back(seg(0, 0, 0, 4*ONE, 0, 0));
        seg_pending.push_back(seg(ONE/4, 0, 0, ONE/4, 0, 0));
        seg_pending.push_back(seg(5*ONE, 5*ONE, 0, 5*ONE, 5*ONE, 0));
        seg_pending.push_back(seg(-2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
        seg_pending.push_back(seg(2*ONE, 0, 0, 4*ONE, 0, 0));
        seg_pending.push_back(seg(-2*ONE, ONE, 0, 2*ONE, ONE, 0));
        seg_pending.push_back(seg(-2*ONE, 0, 0, -ONE/2, 0, 0));
        seg_pending.push_back(seg(0, -2*ONE, 0, 0, 2*ONE, 0));
        seg_pending.push_back(seg(0, 0, -2*ONE, 0, 0, 2*ONE));
        seg_pending.push_back(seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        seg_pending.push_back(seg(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        seg_pending.push_back(seg(-1, -1, -1, -1, -1, -1));
        seg_pending.push_back(seg(32'h8000_0000, 0, 0, 1, 0, 0));
        seg_pending.push_back(seg(-ONE - 1, 0, 0, -ONE - 1 + 1, 0, 0));
        drain_all();

        random_phase(250);

        set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        seg_pending.push_back(seg(32'h8000_0000, 32'h7FFF_FFFF, 0,
                                  32'h7FFF_FFFF, 32'h8000_0000, 0));
        seg_pending.push_back(seg(0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF));
        random_phase(250);

        set_sphere($urandom, $urandom, $urandom, 32'h0);
        seg_pending.push_back(seg(sph_cx - ONE, sph_cy, sph_cz, sph_cx + ONE, sph_cy, sph_cz));
        random_phase(200);

        set_sphere($urandom_range(0, 20*ONE) - 10*ONE, $urandom_range(0, 20*ONE) - 10*ONE,
                   $urandom_range(0, 20*ONE) - 10*ONE, $urandom_range(1, 8*ONE));
        random_phase(300);

        set_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        random_phase(100);

        run_done = 1'b1;
        if (mismatches == 0 && hit_expected.size() == 0) begin
            $display("[segment_sphere_intersect_unit] OK");
        end else begin
            $display("[segment_sphere_intersect_unit] ERROR");
        end
        $finish;
    end
endmodule
